// ----- sv/gwm_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants and types of the glob wildcard matcher.
package gwm_pkg;

    localparam int PATTERN_MAX_DEF = 64;

    // Request operation codes.
    localparam logic [1:0] OP_PAT    = 2'd0;
    localparam logic [1:0] OP_TEXT   = 2'd1;
    localparam logic [1:0] OP_REPORT = 2'd2;

    // Pattern syntax characters.
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_QUEST = 8'h3F;
    localparam logic [7:0] CH_OPEN  = 8'h5B;
    localparam logic [7:0] CH_CLOSE = 8'h5D;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_DASH  = 8'h2D;

    // Parse state handed from one cell to the next.
    localparam int PST_W = 3;
    typedef logic [PST_W-1:0] t_pst;
    localparam t_pst PST_OUT    = 3'd0;
    localparam t_pst PST_OPENED = 3'd1;
    localparam t_pst PST_FIRST  = 3'd2;
    localparam t_pst PST_IN     = 3'd3;
    localparam t_pst PST_DASH   = 3'd4;
    localparam t_pst PST_HI     = 3'd5;

    // Per-cell view of the current text byte.
    typedef struct packed {
        logic star;     // plain '*' outside a class
        logic adv;      // plain position that consumes the byte
        logic cls_v;    // class member that contains the byte
        logic cls_g;    // negation mark of a class
        logic head;     // starts a class segment or stands alone
        logic open;     // opening bracket of a class
        logic cls_end;  // last position of a class
    } t_cell_flags;

endpackage

// ----- sv/glob_wildcard_matcher.sv -----
`timescale 1ns / 1ps
// Glob wildcard matcher top level: request handling, active positions, cell row.
//
// A pattern byte is taken only while idle. The byte that completes a pattern starts a
// parse sweep through the cell row followed by a star closure. For a text byte,
// the class scan and the star closure each run through the doubling scan network,
// one step per cycle. A report's result waits in an output register; the next
// request is taken once that result has been read, or in the same cycle as the read.
module glob_wildcard_matcher #(
    parameter int PATTERN_MAX = gwm_pkg::PATTERN_MAX_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // operation[1:0], byte_value[9:2], zero fill
    input  logic        s_axis_tlast,   // last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // matched[0], error[1], zero fill
);

    localparam int N     = PATTERN_MAX;
    localparam int LW    = $clog2(PATTERN_MAX + 1);
    localparam int STEPS = $clog2(PATTERN_MAX + 1);
    localparam int KW    = $clog2(STEPS);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_PARSE    = 3'd1;
    localparam logic [2:0] S_CLS_LOAD = 3'd2;
    localparam logic [2:0] S_CLS      = 3'd3;
    localparam logic [2:0] S_UPD      = 3'd4;
    localparam logic [2:0] S_CLO      = 3'd5;
    localparam logic [2:0] S_FIN      = 3'd6;

    localparam logic [1:0] SEL_CLS = 2'd0;
    localparam logic [1:0] SEL_NXT = 2'd1;
    localparam logic [1:0] SEL_RST = 2'd2;

    logic [2:0]    r_state;
    logic [2:0]    n_state;
    logic [LW-1:0] r_len;
    logic [LW-1:0] n_len;
    logic          r_complete;
    logic          n_complete;
    logic          r_overflow;
    logic          n_overflow;
    logic [N:0]    r_active;
    logic [N:0]    n_active;
    logic [7:0]    r_c;
    logic [7:0]    n_c;
    logic [KW-1:0] r_k;
    logic [KW-1:0] n_k;
    logic [LW-1:0] r_pcnt;
    logic [LW-1:0] n_pcnt;
    logic          r_ovld;
    logic          n_ovld;
    logic          r_match;
    logic          n_match;
    logic          r_err;
    logic          n_err;

    logic          acc;
    logic [1:0]    op;
    logic [7:0]    in_byte;
    logic [LW-1:0] len_base;
    logic          pat_wr;
    logic          rep_err;
    logic          scan_load;
    logic          scan_step;
    logic [1:0]    load_sel;
    logic          parse_en;

    logic [N+1:0][7:0]           cbyte;
    logic [N+1:0]                used;
    gwm_pkg::t_pst [N-1:0]       pst_out;
    gwm_pkg::t_pst [N-1:0]       pst_in;
    gwm_pkg::t_cell_flags [N-1:0] flg;
    logic [N:0]                  nxt;
    logic [N:0][2:0]             init_v;
    logic [N:0]                  init_s;
    logic [N:0][2:0]             sv;

    assign acc      = s_axis_tvalid && s_axis_tready;
    assign op       = s_axis_tdata[1:0];
    assign in_byte  = s_axis_tdata[9:2];
    assign len_base = r_complete ? '0 : r_len;
    assign pat_wr   = acc && r_state == S_IDLE && op == gwm_pkg::OP_PAT && len_base < LW'(N);
    assign rep_err  = !r_complete || r_overflow;

    assign s_axis_tready = (r_state == S_IDLE) && (!r_ovld || m_axis_tready);
    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = {6'b0, r_err, r_match};

    assign pst_in = {pst_out[N-2:0], gwm_pkg::PST_OUT};
    assign cbyte[N]   = 8'h00;
    assign cbyte[N+1] = 8'h00;
    assign used[N]    = 1'b0;
    assign used[N+1]  = 1'b0;

    for (genvar gi = 0; gi < N; gi++) begin : g_cell
        assign used[gi] = r_len > LW'(gi);
        gwm_cell u_cell (
            .i_clk     (i_clk),
            .i_wr      (pat_wr && len_base == LW'(gi)),
            .i_wr_byte (in_byte),
            .i_parse   (parse_en),
            .i_pst     (pst_in[gi]),
            .i_nb1     (cbyte[gi+1]),
            .i_nb2     (cbyte[gi+2]),
            .i_used2   (used[gi+2]),
            .i_last    (used[gi] && !used[gi+1]),
            .i_c       (r_c),
            .o_byte    (cbyte[gi]),
            .o_pst     (pst_out[gi]),
            .o_flags   (flg[gi])
        );
    end

    // Next active set from the class scan results and the plain positions.
    always_comb begin
        nxt = '0;
        for (int i = 0; i < N; i++) begin
            if (used[i] && r_active[i] && flg[i].star) begin
                nxt[i] = 1'b1;
            end
            if (used[i] && r_active[i] && flg[i].adv) begin
                nxt[i+1] = 1'b1;
            end
            if (used[i] && flg[i].cls_end && sv[i][1] && (sv[i][0] ^ sv[i][2])) begin
                nxt[i+1] = 1'b1;
            end
        end
    end

    // Scan initial values: payload bit 0 is the OR value; for the class scan
    // bit 1 carries the opening bracket's active bit and bit 2 the negation.
    always_comb begin
        init_v = '0;
        init_s = '1;
        if (load_sel == SEL_CLS) begin
            for (int i = 0; i < N; i++) begin
                init_v[i] = {flg[i].cls_g, r_active[i] && flg[i].open, flg[i].cls_v};
                init_s[i] = !used[i] || flg[i].head;
            end
        end else begin
            for (int i = 0; i <= N; i++) begin
                if (load_sel == SEL_RST) begin
                    init_v[i][0] = (i == 0);
                end else begin
                    init_v[i][0] = nxt[i];
                end
                if (i > 0) begin
                    init_s[i] = !(used[i-1] && flg[i-1].star);
                end
            end
        end
    end

    gwm_scan #(
        .N     (N + 1),
        .W     (3),
        .STEPS (STEPS),
        .KW    (KW)
    ) u_scan (
        .i_clk    (i_clk),
        .i_load   (scan_load),
        .i_init_v (init_v),
        .i_init_s (init_s),
        .i_step   (scan_step),
        .i_k      (r_k),
        .o_v      (sv)
    );

    always_comb begin
        n_state    = r_state;
        n_len      = r_len;
        n_complete = r_complete;
        n_overflow = r_overflow;
        n_active   = r_active;
        n_c        = r_c;
        n_k        = r_k;
        n_pcnt     = r_pcnt;
        n_ovld     = r_ovld && !m_axis_tready;
        n_match    = r_match;
        n_err      = r_err;
        scan_load  = 1'b0;
        scan_step  = 1'b0;
        load_sel   = SEL_CLS;
        parse_en   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    case (op)
                        gwm_pkg::OP_PAT: begin
                            n_len      = pat_wr ? len_base + 1'b1 : len_base;
                            n_overflow = (!r_complete && r_overflow) || !pat_wr;
                            n_complete = s_axis_tlast;
                            n_active   = (N + 1)'(1);
                            if (s_axis_tlast) begin
                                n_pcnt  = '0;
                                n_state = S_PARSE;
                            end
                        end
                        gwm_pkg::OP_TEXT: begin
                            if (r_complete && !r_overflow) begin
                                n_c     = in_byte;
                                n_state = S_CLS_LOAD;
                            end
                        end
                        gwm_pkg::OP_REPORT: begin
                            n_err     = rep_err;
                            n_match   = !rep_err && r_active[r_len];
                            n_ovld    = 1'b1;
                            scan_load = 1'b1;
                            load_sel  = SEL_RST;
                            n_k       = '0;
                            n_state   = S_CLO;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_PARSE: begin
                parse_en = 1'b1;
                n_pcnt   = r_pcnt + 1'b1;
                // The parse front settles cell by cell through the row.
                if (r_pcnt == LW'(N)) begin
                    scan_load = 1'b1;
                    load_sel  = SEL_RST;
                    n_k       = '0;
                    n_state   = S_CLO;
                end
            end
            S_CLS_LOAD: begin
                scan_load = 1'b1;
                load_sel  = SEL_CLS;
                n_k       = '0;
                n_state   = S_CLS;
            end
            S_CLS: begin
                scan_step = 1'b1;
                n_k       = r_k + 1'b1;
                if (r_k == KW'(STEPS - 1)) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                scan_load = 1'b1;
                load_sel  = SEL_NXT;
                n_k       = '0;
                n_state   = S_CLO;
            end
            S_CLO: begin
                scan_step = 1'b1;
                n_k       = r_k + 1'b1;
                if (r_k == KW'(STEPS - 1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                for (int i = 0; i <= N; i++) begin
                    n_active[i] = sv[i][0];
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_len      <= '0;
            r_complete <= 1'b0;
            r_overflow <= 1'b0;
            r_active   <= (N + 1)'(1);
            r_ovld     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_len      <= n_len;
            r_complete <= n_complete;
            r_overflow <= n_overflow;
            r_active   <= n_active;
            r_ovld     <= n_ovld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c     <= n_c;
        r_k     <= n_k;
        r_pcnt  <= n_pcnt;
        r_match <= n_match;
        r_err   <= n_err;
    end

endmodule

// ----- sv/gwm_cell.sv -----
`timescale 1ns / 1ps
// One pattern position: stored byte, its parsed role and its local match logic.
module gwm_cell (
    input  logic                  i_clk,
    input  logic                  i_wr,
    input  logic [7:0]            i_wr_byte,
    input  logic                  i_parse,
    input  gwm_pkg::t_pst         i_pst,
    input  logic [7:0]            i_nb1,
    input  logic [7:0]            i_nb2,
    input  logic                  i_used2,
    input  logic                  i_last,
    input  logic [7:0]            i_c,
    output logic [7:0]            o_byte,
    output gwm_pkg::t_pst         o_pst,
    output gwm_pkg::t_cell_flags  o_flags
);

    localparam logic [2:0] R_NORM  = 3'd0;
    localparam logic [2:0] R_OPEN  = 3'd1;
    localparam logic [2:0] R_BANG  = 3'd2;
    localparam logic [2:0] R_LIT   = 3'd3;
    localparam logic [2:0] R_RLO   = 3'd4;
    localparam logic [2:0] R_DASH  = 3'd5;
    localparam logic [2:0] R_RHI   = 3'd6;
    localparam logic [2:0] R_CLOSE = 3'd7;

    logic [7:0]    r_byte;
    logic [2:0]    r_role;
    logic [2:0]    n_role;
    gwm_pkg::t_pst r_pst;
    gwm_pkg::t_pst n_pst;
    logic          member;
    logic          normal;

    always_comb begin
        n_role = R_NORM;
        n_pst  = gwm_pkg::PST_OUT;
        member = 1'b0;
        case (i_pst)
            gwm_pkg::PST_OUT: begin
                if (r_byte == gwm_pkg::CH_OPEN) begin
                    n_role = R_OPEN;
                    n_pst  = gwm_pkg::PST_OPENED;
                end
            end
            gwm_pkg::PST_OPENED: begin
                if (r_byte == gwm_pkg::CH_BANG) begin
                    n_role = R_BANG;
                    n_pst  = gwm_pkg::PST_FIRST;
                end else begin
                    member = 1'b1;
                end
            end
            gwm_pkg::PST_FIRST: begin
                member = 1'b1;
            end
            gwm_pkg::PST_IN: begin
                if (r_byte == gwm_pkg::CH_CLOSE) begin
                    n_role = R_CLOSE;
                    n_pst  = gwm_pkg::PST_OUT;
                end else begin
                    member = 1'b1;
                end
            end
            gwm_pkg::PST_DASH: begin
                n_role = R_DASH;
                n_pst  = gwm_pkg::PST_HI;
            end
            gwm_pkg::PST_HI: begin
                n_role = R_RHI;
                n_pst  = gwm_pkg::PST_IN;
            end
            default: begin
                n_role = R_NORM;
                n_pst  = gwm_pkg::PST_OUT;
            end
        endcase
        // A member starts a range when a dash and a bound other than the
        // closing bracket follow it inside the pattern.
        if (member) begin
            if (i_used2 && i_nb1 == gwm_pkg::CH_DASH && i_nb2 != gwm_pkg::CH_CLOSE) begin
                n_role = R_RLO;
                n_pst  = gwm_pkg::PST_DASH;
            end else begin
                n_role = R_LIT;
                n_pst  = gwm_pkg::PST_IN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_byte <= i_wr_byte;
        end
        if (i_parse) begin
            r_role <= n_role;
            r_pst  <= n_pst;
        end
    end

    assign normal = (r_role == R_NORM);

    always_comb begin
        o_flags.star    = normal && r_byte == gwm_pkg::CH_STAR;
        o_flags.adv     = normal && r_byte != gwm_pkg::CH_STAR
                          && (r_byte == gwm_pkg::CH_QUEST || r_byte == i_c);
        o_flags.cls_v   = (r_role == R_LIT && r_byte == i_c)
                          || (r_role == R_RLO && r_byte <= i_c && i_c <= i_nb2);
        o_flags.cls_g   = (r_role == R_BANG);
        o_flags.head    = normal || r_role == R_OPEN;
        o_flags.open    = (r_role == R_OPEN);
        // An unterminated class ends at the last pattern byte.
        o_flags.cls_end = (r_role == R_CLOSE) || (i_last && r_pst != gwm_pkg::PST_OUT);
    end

    assign o_byte = r_byte;
    assign o_pst  = r_pst;

endmodule

// ----- sv/gwm_scan.sv -----
`timescale 1ns / 1ps
// Segmented OR prefix scan over the cell row, one doubling step per cycle while i_step is high.
module gwm_scan #(
    parameter int N     = gwm_pkg::PATTERN_MAX_DEF + 1,
    parameter int W     = 3,
    parameter int STEPS = $clog2(gwm_pkg::PATTERN_MAX_DEF + 1),
    parameter int KW    = $clog2($clog2(gwm_pkg::PATTERN_MAX_DEF + 1))
) (
    input  logic                  i_clk,
    input  logic                  i_load,
    input  logic [N-1:0][W-1:0]   i_init_v,
    input  logic [N-1:0]          i_init_s,
    input  logic                  i_step,
    input  logic [KW-1:0]         i_k,
    output logic [N-1:0][W-1:0]   o_v
);

    logic [N-1:0][W-1:0] r_v;
    logic [N-1:0][W-1:0] n_v;
    logic [N-1:0][W-1:0] src_v;
    logic [N-1:0]        r_s;
    logic [N-1:0]        n_s;
    logic [N-1:0]        src_s;

    // Element i looks at element i - 2^k unless a segment start stops it.
    always_comb begin
        src_v = '0;
        src_s = '1;
        for (int k = 0; k < STEPS; k++) begin
            if (i_k == KW'(k)) begin
                src_v = r_v << (W * (1 << k));
                src_s = ~((~r_s) << (1 << k));
            end
        end
        for (int i = 0; i < N; i++) begin
            n_v[i] = r_v[i] | (r_s[i] ? '0 : src_v[i]);
        end
        n_s = r_s | src_s;
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_v <= i_init_v;
            r_s <= i_init_s;
        end else if (i_step) begin
            r_v <= n_v;
            r_s <= n_s;
        end
    end

    assign o_v = r_v;

endmodule

// ----- bench/gwm_checker.sv -----
`timescale 1ns / 1ps
// Checker for the glob wildcard matcher: watches both streams, predicts and compares.
module gwm_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [15:0] i_s_tdata,
    input  logic        i_s_tlast,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [7:0]  i_m_tdata,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_match_count
);

    localparam int PMAX = gwm_pkg::PATTERN_MAX_DEF;

    typedef struct packed {
        logic error;
        logic matched;
    } t_verdict;

    logic [7:0] pat_mem [PMAX];
    int         pat_len;
    bit         pat_done;
    bit         pat_ovf;
    bit         active [PMAX+1];
    t_verdict   verdict_q [$];

    assign o_pending = verdict_q.size();

    function automatic logic [7:0] pat_byte(int i);
        return (i < pat_len && i < PMAX) ? pat_mem[i] : 8'h00;
    endfunction

    // Walks the class that opens at pos; nxt is the position after it.
    function automatic bit class_hit(int pos, logic [7:0] c, output int nxt);
        int  p;
        bit  neg;
        bit  hit;
        bit  first;
        logic [7:0] lo;
        p = pos + 1;
        neg = 0;
        hit = 0;
        first = 1;
        if (p < pat_len && pat_byte(p) == gwm_pkg::CH_BANG) begin
            neg = 1;
            p++;
        end
        while (p < pat_len && (pat_byte(p) != gwm_pkg::CH_CLOSE || first)) begin
            lo = pat_byte(p);
            first = 0;
            if (p + 2 < pat_len && pat_byte(p + 1) == gwm_pkg::CH_DASH
                && pat_byte(p + 2) != gwm_pkg::CH_CLOSE) begin
                if (c >= lo && c <= pat_byte(p + 2)) hit = 1;
                p += 3;
            end else begin
                if (c == lo) hit = 1;
                p++;
            end
        end
        if (p < pat_len && pat_byte(p) == gwm_pkg::CH_CLOSE) p++;
        nxt = p;
        return hit != neg;
    endfunction

    function automatic void close_stars();
        for (int i = 0; i < pat_len && i < PMAX; i++)
            if (active[i] && pat_byte(i) == gwm_pkg::CH_STAR) active[i + 1] = 1;
    endfunction

    function automatic void restart_match();
        foreach (active[i]) active[i] = 0;
        active[0] = 1;
    endfunction

    function automatic void advance_text(logic [7:0] c);
        bit nxt_act [PMAX+1];
        int after;
        logic [7:0] pc;
        foreach (nxt_act[i]) nxt_act[i] = 0;
        close_stars();
        for (int i = 0; i < pat_len && i < PMAX; i++) begin
            if (active[i]) begin
                pc = pat_byte(i);
                if (pc == gwm_pkg::CH_STAR) nxt_act[i] = 1;
                else if (pc == gwm_pkg::CH_QUEST) nxt_act[i + 1] = 1;
                else if (pc == gwm_pkg::CH_OPEN) begin
                    if (class_hit(i, c, after) && after <= PMAX) nxt_act[after] = 1;
                end else if (pc == c) nxt_act[i + 1] = 1;
            end
        end
        active = nxt_act;
        close_stars();
    endfunction

    task automatic apply_request(logic [1:0] op, logic [7:0] b, logic lst);
        t_verdict v;
        case (op)
            gwm_pkg::OP_PAT: begin
                if (pat_done) begin
                    pat_len = 0;
                    pat_done = 0;
                    pat_ovf = 0;
                end
                if (pat_len < PMAX) begin
                    pat_mem[pat_len] = b;
                    pat_len++;
                end else begin
                    pat_ovf = 1;
                end
                if (lst) pat_done = 1;
                restart_match();
            end
            gwm_pkg::OP_TEXT: begin
                if (pat_done && !pat_ovf) advance_text(b);
            end
            gwm_pkg::OP_REPORT: begin
                v.error = !pat_done || pat_ovf;
                v.matched = 0;
                if (!v.error) begin
                    close_stars();
                    v.matched = pat_len <= PMAX && active[pat_len];
                end
                verdict_q.push_back(v);
                restart_match();
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(string what);
        $display("%0t ns: mismatch: %s", $time, what);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        o_match_count = 0;
        pat_len = 0;
        pat_done = 0;
        pat_ovf = 0;
        restart_match();
    end

    always @(posedge i_clk) begin
        t_verdict want;
        if (i_rst_n) begin
            if (i_m_tvalid && i_m_tready) begin
                if (verdict_q.size() == 0) begin
                    report_mismatch($sformatf("result %h with none expected", i_m_tdata));
                end else begin
                    want = verdict_q.pop_front();
                    if (i_m_tdata[0] !== want.matched)
                        report_mismatch($sformatf("matched %b, expected %b",
                                                  i_m_tdata[0], want.matched));
                    if (i_m_tdata[1] !== want.error)
                        report_mismatch($sformatf("error %b, expected %b",
                                                  i_m_tdata[1], want.error));
                    if (i_m_tdata[7:2] !== 6'd0)
                        report_mismatch($sformatf("fill bits %b not zero", i_m_tdata[7:2]));
                    if (want.matched) o_match_count++;
                end
            end
            if (i_s_tvalid && i_s_tready)
                apply_request(i_s_tdata[1:0], i_s_tdata[9:2], i_s_tlast);
        end
    end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// Top of the glob wildcard matcher bench: clock, reset, stimulus and verdict.
module testbench;

    localparam int IDLE_LIMIT = 4000;
    localparam int N_ITEMS = 750;

    // Operation code that the block ignores.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = 0;   // operation[1:0], byte_value[9:2], zero fill
    logic        s_axis_tlast = 0;   // last
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [7:0]  m_axis_tdata;       // matched[0], error[1], zero fill

    int fail_count;
    int pending;
    int match_count;
    int sent;
    int reports;
    int idle_cycles;
    int stall_left;
    bit quiet;

    typedef logic [7:0] t_bytes [$];

    always #5 i_clk = ~i_clk;

    glob_wildcard_matcher dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    gwm_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_axis_tvalid), .i_s_tready(s_axis_tready),
        .i_s_tdata(s_axis_tdata), .i_s_tlast(s_axis_tlast),
        .i_m_tvalid(m_axis_tvalid), .i_m_tready(m_axis_tready),
        .i_m_tdata(m_axis_tdata),
        .o_fail_count(fail_count), .o_pending(pending), .o_match_count(match_count)
    );

    // Receiver stalls come in bursts; none once the run goes quiet.
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            m_axis_tready = 0;
            stall_left--;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            m_axis_tready = 0;
            stall_left = $urandom_range(1, 9) - 1;
        end else begin
            m_axis_tready = 1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
            $display("FAIL glob_wildcard_matcher");
            $finish;
        end else
            idle_cycles <= idle_cycles + 1;
    end

    // Called right after a falling edge; returns once the request is taken.
    task automatic push(logic [1:0] op, logic [7:0] b, logic lst);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid = 0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        s_axis_tvalid = 1;
        s_axis_tdata = {6'd0, b, op};
        s_axis_tlast = lst;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        sent++;
        if (op == gwm_pkg::OP_REPORT) reports++;
    endtask

    task automatic load_pattern(t_bytes pat);
        foreach (pat[i]) push(gwm_pkg::OP_PAT, pat[i], i == pat.size() - 1);
    endtask

    task automatic check_text(t_bytes txt);
        foreach (txt[i]) push(gwm_pkg::OP_TEXT, txt[i], 1'($urandom_range(0, 1)));
        push(gwm_pkg::OP_REPORT, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    function automatic t_bytes str_bytes(string s);
        t_bytes q;
        for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
        return q;
    endfunction

    function automatic t_bytes rand_bytes(int n, string alphabet);
        t_bytes q;
        for (int i = 0; i < n; i++)
            if ($urandom_range(0, 9) == 0) q.push_back(8'($urandom_range(0, 255)));
            else q.push_back(alphabet[$urandom_range(0, alphabet.len() - 1)]);
        return q;
    endfunction

    initial begin
        t_bytes pat;
        t_bytes txt;
        stall_left = 0;
        idle_cycles = 0;
        sent = 0;
        reports = 0;
        quiet = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // Text and a report before any pattern exists; an unused operation.
        push(gwm_pkg::OP_TEXT, 8'hFF, 1'b0);
        check_text(str_bytes(""));
        push(OP_UNUSED, 8'hA5, 1'b1);
        // A pattern left open reports an error.
        push(gwm_pkg::OP_PAT, "a", 1'b0);
        check_text(str_bytes("a"));
        push(gwm_pkg::OP_PAT, "*", 1'b1);
        check_text(str_bytes(""));
        load_pattern(str_bytes("a**[]b-d]?[!"));
        txt = str_bytes("axxc");
        txt.push_back(8'h00);
        check_text(txt);
        load_pattern(str_bytes("[z-a]"));
        check_text(str_bytes("m"));
        load_pattern(str_bytes("["));
        check_text(str_bytes("["));

        while (sent < N_ITEMS) begin
            if (sent > N_ITEMS - 120) quiet = 1;
            case ($urandom_range(0, 19))
                0, 1: begin
                    // Loose requests of any kind, the unused operation among them.
                    repeat ($urandom_range(1, 4))
                        push(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1)));
                end
                2: begin
                    // Patterns that nearly fill the store, fill it exactly or overflow it.
                    pat = rand_bytes($urandom_range(63, 66), "ab*?");
                    load_pattern(pat);
                    check_text(rand_bytes($urandom_range(0, 4), "ab"));
                end
                default: begin
                    load_pattern(rand_bytes($urandom_range(1, 8), "ab*?[]!-c"));
                    repeat ($urandom_range(1, 3))
                        check_text(rand_bytes($urandom_range(0, 10), "abc]-!*"));
                end
            endcase
        end
        s_axis_tvalid = 0;

        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        $display("Sent %0d requests, %0d of them reports; %0d reports matched.",
                 sent, reports, match_count);
        if (fail_count == 0)
            $display("PASS glob_wildcard_matcher");
        else
            $display("FAIL glob_wildcard_matcher");
        $finish;
    end

endmodule
